// ===== design/krhm_pkg.sv =====
`default_nettype none

package krhm_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_FULL_SCALE    = 2'd1;
  localparam logic [1:0] REG_MAX_HEIGHT    = 2'd2;

  // Item kinds on the input stream.
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] WINDOW_LENGTH_RST = 16'd500;
  localparam logic [7:0]  FULL_SCALE_RST    = 8'd120;
  localparam logic [7:0]  MAX_HEIGHT_RST    = 8'd40;

  // Rate arithmetic constants.
  localparam logic [29:0] RATE_SCALE   = 30'd12000;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [7:0]  RATE_MAX     = 8'hFF;
  localparam int          EMIT_LIMIT   = 16;
  localparam logic [2:0]  DIV_LAST_STEP = 3'd7;

  // Bar heights for the special cases.
  localparam logic [7:0] BAR_ZERO = 8'd1;
  localparam logic [7:0] BAR_MIN  = 8'd2;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R_START,
    ST_R_WAIT,
    ST_R_WRITE,
    ST_RD_ISSUE,
    ST_RD_CAP,
    ST_B_START,
    ST_B_WAIT,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;
    logic div_rate;
    logic rate_load;
    logic hist_wr;
    logic rd_capture;
    logic div_bar;
    logic bar_load;
    logic emit_next;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;
    logic div_done;
    logic last_item;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/krhm_ram.sv =====
`default_nettype none

module krhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/krhm_div.sv =====
`default_nettype none

module krhm_div
  import krhm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [29:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [7:0]       quot
);

  logic [29:0] rem;
  logic [38:0] dsh;
  logic [7:0]  q;
  logic [2:0]  cnt;
  logic        busy;
  logic        sat;

  // Control: busy for eight restoring steps, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DIV_LAST_STEP);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_LAST_STEP)) begin
        busy <= 1'b0;
      end
    end
  end

  // One quotient bit per cycle; a quotient of 256 or more saturates.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, 7'b0};
      cnt <= 3'd0;
      sat <= {10'b0, num} >= {den, 8'b0};
    end else if (busy) begin
      if ({9'b0, rem} >= dsh) begin
        rem <= rem - dsh[29:0];
        q   <= {q[6:0], 1'b1};
      end else begin
        q   <= {q[6:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt + 3'd1;
    end
  end

  assign quot = sat ? RATE_MAX : q;

endmodule

`default_nettype wire

// ===== design/krhm_ctrl.sv =====
`default_nettype none

module krhm_ctrl
  import krhm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  output logic            s_ready,
  output logic            m_valid,
  input  wire logic       m_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_valid && status.close) begin
          state_next = ST_R_START;
        end
      end
      ST_R_START:  state_next = ST_R_WAIT;
      ST_R_WAIT: begin
        if (status.div_done) begin
          state_next = ST_R_WRITE;
        end
      end
      ST_R_WRITE:  state_next = ST_RD_ISSUE;
      ST_RD_ISSUE: state_next = ST_RD_CAP;
      ST_RD_CAP:   state_next = ST_B_START;
      ST_B_START:  state_next = ST_B_WAIT;
      ST_B_WAIT: begin
        if (status.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_ready) begin
          state_next = status.last_item ? ST_IDLE : ST_RD_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    s_ready = 1'b0;
    m_valid = 1'b0;
    cmd     = '0;
    unique case (state)
      ST_IDLE: begin
        s_ready     = 1'b1;
        cmd.take_in = s_valid;
      end
      ST_R_START:  cmd.div_rate  = 1'b1;
      ST_R_WAIT:   cmd.rate_load = status.div_done;
      ST_R_WRITE:  cmd.hist_wr   = 1'b1;
      ST_RD_ISSUE: ;
      ST_RD_CAP:   cmd.rd_capture = 1'b1;
      ST_B_START:  cmd.div_bar   = 1'b1;
      ST_B_WAIT:   cmd.bar_load  = status.div_done;
      ST_OUT: begin
        m_valid       = 1'b1;
        cmd.emit_next = m_ready;
      end
      default: ;
    endcase
  end

  // The input side is closed for the whole closing run.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_ready && m_valid))
    else $error("input taken while a result is shown");

  // After the last result of a run the block is ready for input again.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_ready && status.last_item) |=> s_ready)
    else $error("run did not return to idle after its last result");

  // A division finishes only while the controller waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_R_WAIT || state == ST_B_WAIT))
    else $error("division finished outside a wait state");

  // A history write is always followed by a read sweep, never by idle.
  a_wr_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.hist_wr |=> (state == ST_RD_ISSUE))
    else $error("history write not followed by a read");

endmodule

`default_nettype wire

// ===== design/krhm_dp.sv =====
`default_nettype none

module krhm_dp
  import krhm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_cmd,
  input  wire logic        in_key_down,
  input  wire logic [31:0] in_now_ms,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  output logic [3:0]       bar_index,
  output logic [7:0]       window_rate,
  output logic [7:0]       bar_height
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int EMIT_N = (HISTORY_DEPTH < EMIT_LIMIT) ? HISTORY_DEPTH : EMIT_LIMIT;
  localparam logic [AW-1:0] PTR_LAST   = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   PTR_DEPTH  = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW:0]   PTR_OFFSET = (AW + 1)'(HISTORY_DEPTH - EMIT_N);
  localparam logic [3:0]    IDX_LAST   = 4'(EMIT_N - 1);

  logic [15:0] window_length_ms;
  logic [7:0]  full_scale_rate;
  logic [7:0]  max_bar_height;

  logic [15:0] press_count;
  logic [31:0] window_begin;
  logic        started;
  logic [31:0] elapsed;
  logic [31:0] elapsed_q;
  logic [29:0] rate_prod;
  logic        count_zero;
  logic [7:0]  rate_q;

  logic [HISTORY_DEPTH-1:0] valid;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] wr_ptr_inc;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   start_sum;
  logic [7:0]    ram_rdata;
  logic [15:0]   bar_prod;
  logic [3:0]    idx;

  logic        div_start;
  logic [29:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [7:0]  div_quot;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_ms <= WINDOW_LENGTH_RST;
      full_scale_rate  <= FULL_SCALE_RST;
      max_bar_height   <= MAX_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length_ms <= cfg_data;
        REG_FULL_SCALE:    full_scale_rate  <= cfg_data[7:0];
        REG_MAX_HEIGHT:    max_bar_height   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Window decision for the item on the input.
  assign elapsed = in_now_ms - window_begin;
  assign status.close = (in_cmd == KIND_TICK) && started &&
                        (elapsed >= {16'b0, window_length_ms});

  // Press counting and window bookkeeping on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_count  <= '0;
      window_begin <= '0;
      started      <= 1'b0;
    end else if (cmd.take_in) begin
      if (in_cmd == KIND_KEY) begin
        if (in_key_down && (press_count != COUNT_MAX)) begin
          press_count <= press_count + 16'd1;
        end
      end else if (!started) begin
        started      <= 1'b1;
        window_begin <= in_now_ms;
      end else if (status.close) begin
        press_count  <= '0;
        window_begin <= in_now_ms;
      end
    end
  end

  // Snapshot of the closing window: scaled count and elapsed time.
  always_ff @(posedge clk) begin
    if (cmd.take_in && status.close) begin
      rate_prod  <= 30'({14'b0, press_count} * RATE_SCALE);
      count_zero <= (press_count == 16'd0);
      elapsed_q  <= elapsed;
    end
  end

  // Shared divider: window rate first, then one bar height per result.
  assign div_start = cmd.div_rate || cmd.div_bar;
  assign div_num   = cmd.div_bar ? {14'b0, bar_prod} : rate_prod;
  assign div_den   = cmd.div_bar ? {24'b0, full_scale_rate} : elapsed_q;

  krhm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign status.div_done = div_done;

  // Clamped window rate; no presses always gives zero.
  always_ff @(posedge clk) begin
    if (cmd.rate_load) begin
      rate_q <= count_zero ? 8'd0 : div_quot;
    end
  end

  // History ring: write pointer marks the oldest entry.
  assign wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
  assign start_sum  = {1'b0, wr_ptr_inc} + PTR_OFFSET;

  krhm_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .waddr (wr_ptr),
    .wdata (rate_q),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // Valid bits stand in for clearing the history at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      wr_ptr <= '0;
    end else if (cmd.hist_wr) begin
      valid[wr_ptr] <= 1'b1;
      wr_ptr        <= wr_ptr_inc;
    end
  end

  // Read sweep over the newest entries, oldest first.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      idx    <= '0;
    end else if (cmd.hist_wr) begin
      rd_ptr <= (start_sum >= PTR_DEPTH) ? AW'(start_sum - PTR_DEPTH) : AW'(start_sum);
      idx    <= '0;
    end else if (cmd.emit_next) begin
      rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      idx    <= idx + 4'd1;
    end
  end

  assign status.last_item = (idx == IDX_LAST);

  // Capture the stored rate and scale it for the bar.
  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      window_rate <= valid[rd_ptr] ? ram_rdata : 8'd0;
      bar_prod    <= 16'(valid[rd_ptr] ? ram_rdata : 8'd0) * 16'(max_bar_height);
      bar_index   <= idx;
    end
  end

  // Bar height with its floor and the zero-rate marker.
  always_ff @(posedge clk) begin
    if (cmd.bar_load) begin
      if (window_rate == 8'd0) begin
        bar_height <= BAR_ZERO;
      end else if (div_quot < BAR_MIN) begin
        bar_height <= BAR_MIN;
      end else begin
        bar_height <= div_quot;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/keystroke_rate_history_meter_unit.sv =====
// Keystroke rate meter with a rolling history of window rates.
//
// Input stream: tuser[0] is the item kind (0 key event, 1 timer tick);
// tdata carries key_down in bit 0 and the millisecond timestamp in bits
// 32:1. Key events count presses and are taken while idle. A tick that
// closes a window (elapsed >= window length) computes the window rate,
// pushes it into the history and then sends one result for each of the
// newest entries, at most 16, oldest first, with tlast on the last one.
//
// Sequence: a closing tick runs the rate division and the history write,
// then for each result a history read, multiply, 8-step bar division and
// output. Both divisions share one restoring divider that yields one
// quotient bit per cycle. No input is taken during a run; a stalled
// receiver holds the run, the result stays in the output register until
// it is taken.
//
// Reset sets the registers to their defaults (500 ms, 120, 40), clears the
// count, the window start and the history. The first tick after reset
// only marks the start of the first window.
`default_nettype none

module keystroke_rate_history_meter_unit
  import krhm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // key_down[0], now_ms[32:1], zero fill
  input  wire logic [0:0]  s_axis_tuser,   // cmd[0]
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // bar_index[3:0], window_rate[11:4],
                                           // bar_height[19:12], zero fill
  output logic             m_axis_tlast,
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [3:0] bar_index;
  logic [7:0] window_rate;
  logic [7:0] bar_height;

  krhm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  krhm_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_cmd      (s_axis_tuser[0]),
    .in_key_down (s_axis_tdata[0]),
    .in_now_ms   (s_axis_tdata[32:1]),
    .cmd         (cmd),
    .status      (status),
    .bar_index   (bar_index),
    .window_rate (window_rate),
    .bar_height  (bar_height)
  );

  // Result packing.
  assign m_axis_tdata = {4'b0, bar_height, window_rate, bar_index};
  assign m_axis_tlast = status.last_item;

endmodule

`default_nettype wire

// ===== tb/sv/krhm_result_checker.sv =====
`timescale 1ns / 100ps

// Watches the input, result and configuration channels of the keystroke rate
// meter, keeps its own copy of the meter state and compares each result item
// with the oldest predicted bar.
module krhm_result_checker
  import krhm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // key_down[0], now_ms[32:1], zero fill
  input  wire logic [0:0]  s_axis_tuser,   // cmd[0]
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,   // bar_index[3:0], window_rate[11:4],
                                           // bar_height[19:12], zero fill
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int HISTORY = 16;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [3:0] index;
    logic [7:0] rate;
    logic [7:0] height;
    logic       last;
  } bar_result_t;

  // Mirrored configuration and meter state.
  logic [15:0] win_len;
  logic [7:0]  full_scale;
  logic [7:0]  max_height;
  logic [15:0] presses;
  logic [31:0] win_begin;
  logic        running;
  logic [7:0]  history [HISTORY];

  bar_result_t expected_bars [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < PRINT_LIMIT) begin
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // Scales a stored rate to a bar height in pixels.
  function automatic logic [7:0] bar_height_for(input logic [7:0] rate);
    logic [15:0] h;
    if (rate == 8'd0) begin
      return BAR_ZERO;
    end
    if (full_scale == 8'd0) begin
      return RATE_MAX;
    end
    h = (16'(rate) * 16'(max_height)) / 16'(full_scale);
    if (h < 16'(BAR_MIN)) begin
      return BAR_MIN;
    end
    if (h > 16'(RATE_MAX)) begin
      return RATE_MAX;
    end
    return h[7:0];
  endfunction

  // Applies one input item to the mirrored state and queues any bars it causes.
  task automatic advance_meter(input logic kind, input logic down, input logic [31:0] now);
    logic [31:0] elapsed;
    logic [63:0] scaled;
    logic [7:0]  rate;
    bar_result_t bar;
    if (kind == KIND_KEY) begin
      if (down && presses != COUNT_MAX) begin
        presses++;
      end
      return;
    end
    if (!running) begin
      running = 1'b1;
      win_begin = now;
      return;
    end
    elapsed = now - win_begin;
    if (elapsed < 32'(win_len)) begin
      return;
    end
    if (elapsed == 32'd0) begin
      rate = (presses != 16'd0) ? RATE_MAX : 8'd0;
    end else begin
      scaled = (64'(presses) * 64'(RATE_SCALE)) / 64'(elapsed);
      rate = (scaled > 64'(RATE_MAX)) ? RATE_MAX : scaled[7:0];
    end
    for (int i = 0; i < HISTORY - 1; i++) begin
      history[i] = history[i + 1];
    end
    history[HISTORY - 1] = rate;
    presses = 16'd0;
    win_begin = now;
    for (int k = 0; k < HISTORY; k++) begin
      bar.index = 4'(k);
      bar.rate = history[k];
      bar.height = bar_height_for(history[k]);
      bar.last = (k == HISTORY - 1);
      expected_bars.push_back(bar);
    end
  endtask

  // Tracks configuration writes and accepted items on both streams.
  always @(posedge clk) begin : watch_channels
    bar_result_t got;
    bar_result_t want;
    if (rst) begin
      win_len = WINDOW_LENGTH_RST;
      full_scale = FULL_SCALE_RST;
      max_height = MAX_HEIGHT_RST;
      presses = 16'd0;
      win_begin = 32'd0;
      running = 1'b0;
      for (int i = 0; i < HISTORY; i++) begin
        history[i] = 8'd0;
      end
      expected_bars.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: win_len = cfg_data;
          REG_FULL_SCALE:    full_scale = cfg_data[7:0];
          REG_MAX_HEIGHT:    max_height = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_meter(s_axis_tuser[0], s_axis_tdata[0], s_axis_tdata[32:1]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tdata[19:12], m_axis_tlast};
        if (expected_bars.size() == 0) begin
          report_mismatch("result item with none pending, bar_index", got.index, -1);
        end else begin
          want = expected_bars.pop_front();
          if (got.index != want.index) begin
            report_mismatch("bar_index", got.index, want.index);
          end
          if (got.rate != want.rate) begin
            report_mismatch("window_rate", got.rate, want.rate);
          end
          if (got.height != want.height) begin
            report_mismatch("bar_height", got.height, want.height);
          end
          if (got.last != want.last) begin
            report_mismatch("tlast", got.last, want.last);
          end
        end
      end
    end
    pending = expected_bars.size();
  end

endmodule

// ===== tb/sv/tb_keystroke_rate_history_meter_unit.sv =====
`timescale 1ns / 100ps

module tb_keystroke_rate_history_meter_unit;
  import krhm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;
  // A tick this far past a known window start always closes the window.
  localparam logic [31:0] RESYNC_MS = 32'd65536;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_WINDOW_LENGTH;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int stall_cycles = 0;
  logic [31:0] window_mark = '0;  // time of the last tick known to close a window
  logic [15:0] cur_window = WINDOW_LENGTH_RST;

  keystroke_rate_history_meter_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  krhm_result_checker bar_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result receiver: random stalls, or a long hold-off when one is requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run when nothing has moved on either stream for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_keystroke_rate_history_meter_unit: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one item, with a random gap before it, and waits until it is taken.
  task automatic send_item(input logic kind, input logic down, input logic [31:0] now);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {7'd0, now, down};
    s_axis_tuser <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic key_event(input logic down);
    send_item(KIND_KEY, down, $urandom());
  endtask

  task automatic timer_tick(input logic [31:0] now);
    send_item(KIND_TICK, 1'($urandom_range(1)), now);
  endtask

  // Stops offering and waits until every predicted result item has arrived.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] win, input logic [7:0] full,
                            input logic [7:0] maxh);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data <= win;
    @(negedge clk);
    cfg_index <= REG_FULL_SCALE;
    cfg_data <= {8'd0, full};
    @(negedge clk);
    cfg_index <= REG_MAX_HEIGHT;
    cfg_data <= {8'd0, maxh};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_window = win;
  endtask

  // A tick at a random time, then one that closes the window whether or not
  // the first one did.
  task automatic noise_and_resync();
    logic [31:0] t;
    t = $urandom();
    timer_tick(t);
    window_mark = t + RESYNC_MS;
    timer_tick(window_mark);
  endtask

  // Mostly complete windows with random press counts, plus stray keys and noise.
  task automatic random_windows(input int count);
    int sent;
    int choice;
    int taps;
    int extra;
    sent = 0;
    while (sent < count) begin
      choice = $urandom_range(99);
      if (choice < 80) begin
        taps = $urandom_range(0, 14);
        repeat (taps) begin
          if ($urandom_range(3) == 0) begin
            key_event(1'b0);
            sent++;
          end
          key_event(1'b1);
          sent++;
        end
        if ($urandom_range(3) == 0 && cur_window > 0) begin
          timer_tick(window_mark + $urandom_range(0, int'(cur_window) - 1));
          sent++;
        end
        extra = ($urandom_range(4) == 0) ? 0 : $urandom_range(0, int'(cur_window) / 2 + 1);
        window_mark = window_mark + 32'(cur_window) + 32'(extra);
        timer_tick(window_mark);
        sent++;
      end else if (choice < 90) begin
        repeat (3) key_event(1'($urandom_range(1)));
        sent += 3;
      end else begin
        noise_and_resync();
        sent += 2;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 15;
    recv_idle_pct = 54;

    // Presses before the first tick belong to the first window.
    key_event(1'b0);
    key_event(1'b1);
    key_event(1'b1);
    timer_tick(32'd1000);
    // A short window changes nothing; the next tick closes at exactly 500 ms.
    repeat (3) key_event(1'b1);
    timer_tick(32'd1499);
    timer_tick(32'd1500);
    timer_tick(32'd2000);
    // Window start near the top of the time range, elapsed wraps to 500 ms.
    timer_tick(32'hFFFF_FF0C);
    key_event(1'b1);
    timer_tick(32'h0000_0100);
    window_mark = 32'h0000_0100;
    wait_drained();

    // Zero window length and zero full scale: zero elapsed with and without presses.
    set_config(16'd0, 8'd0, 8'd0);
    key_event(1'b1);
    key_event(1'b1);
    timer_tick(window_mark);
    timer_tick(window_mark);
    wait_drained();

    // Zero max height; timestamps at both ends of the range, rate clamps.
    set_config(16'd0, 8'd255, 8'd0);
    key_event(1'b1);
    timer_tick(32'hFFFF_FFFF);
    key_event(1'b1);
    timer_tick(32'h0000_0000);
    window_mark = 32'h0000_0000;
    wait_drained();

    set_config(WINDOW_LENGTH_RST, FULL_SCALE_RST, MAX_HEIGHT_RST);
    random_windows(50);
    wait_drained();
    set_config(16'd12000, 8'd255, 8'd255);
    random_windows(40);
    wait_drained();

    // Sender idles heavily, receiver lightly.
    send_idle_pct = 54;
    recv_idle_pct = 15;
    set_config(16'd1000, 8'd1, 8'd255);
    random_windows(40);
    wait_drained();
    set_config(16'd65535, 8'd200, 8'd7);
    random_windows(30);
    wait_drained();

    // No idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(16'd1, 8'd37, 8'd91);
    random_windows(40);

    // Receiver holds off while the sender keeps offering behind a closing tick.
    window_mark = window_mark + 32'(cur_window);
    timer_tick(window_mark);
    hold_req = HOLD_CYCLES;
    repeat (6) key_event(1'b1);
    window_mark = window_mark + 32'(cur_window);
    timer_tick(window_mark);
    wait_drained();

    set_config(16'd700, 8'd99, 8'd180);
    random_windows(70);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_keystroke_rate_history_meter_unit: clean");
    end else begin
      $display("tb_keystroke_rate_history_meter_unit: errors");
    end
    $finish;
  end

endmodule
